>>> rtl/exposure_filmic_tone_map_assert.svh
// assertion macros for the tone map rtl
`ifndef EXPOSURE_FILMIC_TONE_MAP_ASSERT_SVH
`define EXPOSURE_FILMIC_TONE_MAP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define EFTM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define EFTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/eftm_pkg.sv
package eftm_pkg;

   // pipeline shape
   localparam int unsigned FRONT_STAGES = 9;
   localparam int unsigned DIV_STAGES   = 8;
   localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

   // datapath widths
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned EV_W    = 8;
   localparam int unsigned GAIN_W  = 27;
   localparam int unsigned POW_W   = 17;
   localparam int unsigned PROD_W  = 35;
   localparam int unsigned M_W     = 31;
   localparam int unsigned RPROD_W = 56;
   localparam int unsigned X_W     = 23;
   localparam int unsigned KPROD_W = 41;
   localparam int unsigned TV_W    = 24;
   localparam int unsigned NUM_W   = 47;
   localparam int unsigned REM_W   = 56;

   // rounding and division by 255
   localparam logic [PIX_W-1:0]   PIX_MAX  = 8'd255;
   localparam logic [11:0]        X_ROUND  = 12'd2040;
   localparam logic [24:0]        RECIP    = 25'd16843009;
   localparam int unsigned        RECIP_SH = 32;
   localparam logic [16:0]        HALF_LSB = 17'd32768;
   localparam int unsigned        Q_SH     = 16;

   // curve coefficients, 16 fractional bits
   localparam logic [17:0] K_A = 18'd164495;
   localparam logic [10:0] K_B = 11'd1966;
   localparam logic [17:0] K_C = 18'd159252;
   localparam logic [15:0] K_D = 16'd38666;
   localparam logic [13:0] K_E = 14'd9175;

   // exposure range in sixteenths of a stop
   localparam logic signed [EV_W-1:0] EV_MIN = -8'sd64;
   localparam logic signed [EV_W-1:0] EV_MAX = 8'sd96;
   localparam logic [8:0]             EV_BIAS = 9'd64;

   // gain with 20 fractional bits
   localparam logic [GAIN_W-1:0] GAIN_RESET = 27'd1048576;
   localparam logic [GAIN_W-1:0] GAIN_MIN   = 27'd65536;
   localparam logic [GAIN_W-1:0] GAIN_MAX   = 27'd67108864;

   // round(2^(k/16) * 65536)
   localparam logic [POW_W-1:0] POW_TABLE [16] = '{
      17'd65536,  17'd68438,  17'd71468,  17'd74632,
      17'd77936,  17'd81386,  17'd84990,  17'd88752,
      17'd92682,  17'd96785,  17'd101070, 17'd105545,
      17'd110218, 17'd115098, 17'd120194, 17'd125515
   };

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } eftm_pix_in_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
   } eftm_pix_out_type;

   // saturate the ev and build the gain from the fraction table
   function automatic logic [GAIN_W-1:0] gain_from_ev(input logic signed [EV_W-1:0] ev);
      logic signed [EV_W-1:0] ev_sat;
      logic [8:0]             u;
      ev_sat = ev;
      if (ev < EV_MIN) begin
         ev_sat = EV_MIN;
      end
      if (ev > EV_MAX) begin
         ev_sat = EV_MAX;
      end
      u = {ev_sat[EV_W-1], ev_sat} + EV_BIAS;
      return {10'd0, POW_TABLE[u[3:0]]} << u[7:4];
   endfunction

endpackage

>>> rtl/eftm_chan.sv
module eftm_chan
   import eftm_pkg::*;
(
   input  logic                  clock,
   input  logic [NUM_STAGES-1:0] stage_load,
   input  logic [GAIN_W-1:0]     gain,
   input  logic [PIX_W-1:0]      chan_in,
   output logic [PIX_W-1:0]      chan_out
);

   // stage 0: channel times gain
   logic [PROD_W-1:0]  p_ff, p_in;
   // stage 1: rounded and divided by 16
   logic [M_W-1:0]     m1_ff, m1_in;
   // stage 2: reciprocal product for the divide by 255
   logic [M_W-1:0]     m2_ff;
   logic [RPROD_W-1:0] rp_ff, rp_in;
   // stage 3: corrected quotient, x in q7.16
   logic [X_W-1:0]     e3;
   logic [M_W-1:0]     e255, rem3;
   logic [X_W-1:0]     x3_ff, x3_in;
   // stage 4: coefficient products
   logic [KPROD_W-1:0] ka_ff, ka_in, kc_ff, kc_in;
   logic [X_W-1:0]     x4_ff;
   // stage 5: t and v terms
   logic [TV_W-1:0]    t_ff, t_in, v_ff, v_in;
   logic [X_W-1:0]     x5_ff;
   // stage 6: x*t and x*v
   logic [NUM_W-1:0]   num6_ff, num6_in, xv_ff, xv_in;
   // stage 7: denominator
   logic [NUM_W-1:0]   num7_ff, den7_ff, den7_in;
   // stage 8: saturation flag and dividend
   logic               sat8_ff, sat8_in;
   logic [REM_W-1:0]   rem8_ff, rem8_in;
   logic [NUM_W-1:0]   den8_ff;

   // divider stages, one quotient bit each
   logic [REM_W-1:0]   dv_rem_ff [DIV_STAGES];
   logic [NUM_W-1:0]   dv_den_ff [DIV_STAGES];
   logic [PIX_W-1:0]   dv_quo_ff [DIV_STAGES];
   logic               dv_sat_ff [DIV_STAGES];

   // front arithmetic
   always_comb begin
      p_in    = PROD_W'(chan_in) * PROD_W'(gain);
      m1_in   = M_W'((p_ff + PROD_W'(X_ROUND)) >> 4);
      rp_in   = RPROD_W'(m1_ff) * RPROD_W'(RECIP);
      e3      = rp_ff[RECIP_SH +: X_W];
      e255    = {e3, 8'd0} - {8'd0, e3};
      rem3    = m2_ff - e255;
      x3_in   = e3 + X_W'(rem3 >= M_W'(PIX_MAX));
      ka_in   = KPROD_W'(x3_ff) * KPROD_W'(K_A);
      kc_in   = KPROD_W'(x3_ff) * KPROD_W'(K_C);
      t_in    = TV_W'((ka_ff + KPROD_W'(HALF_LSB)) >> Q_SH) + TV_W'(K_B);
      v_in    = TV_W'((kc_ff + KPROD_W'(HALF_LSB)) >> Q_SH) + TV_W'(K_D);
      num6_in = NUM_W'(x5_ff) * NUM_W'(t_ff);
      xv_in   = NUM_W'(x5_ff) * NUM_W'(v_ff);
      den7_in = xv_ff + (NUM_W'(K_E) << Q_SH);
      sat8_in = num7_ff >= den7_ff;
      rem8_in = (REM_W'(num7_ff) << 9) - (REM_W'(num7_ff) << 1) + REM_W'(den7_ff);
   end

   // front stage registers
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         p_ff <= p_in;
      end
      if (stage_load[1]) begin
         m1_ff <= m1_in;
      end
      if (stage_load[2]) begin
         m2_ff <= m1_ff;
         rp_ff <= rp_in;
      end
      if (stage_load[3]) begin
         x3_ff <= x3_in;
      end
      if (stage_load[4]) begin
         ka_ff <= ka_in;
         kc_ff <= kc_in;
         x4_ff <= x3_ff;
      end
      if (stage_load[5]) begin
         t_ff  <= t_in;
         v_ff  <= v_in;
         x5_ff <= x4_ff;
      end
      if (stage_load[6]) begin
         num6_ff <= num6_in;
         xv_ff   <= xv_in;
      end
      if (stage_load[7]) begin
         num7_ff <= num6_ff;
         den7_ff <= den7_in;
      end
      if (stage_load[8]) begin
         sat8_ff <= sat8_in;
         rem8_ff <= rem8_in;
         den8_ff <= den7_ff;
      end
   end

   // restoring divide of (510*num + den) by 2*den
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [REM_W-1:0] rem_src, rem_in;
      logic [NUM_W-1:0] den_src;
      logic [PIX_W-1:0] quo_src, quo_in;
      logic             sat_src;
      logic [REM_W:0]   diff;

      if (j == 0) begin : g_first
         assign rem_src = rem8_ff;
         assign den_src = den8_ff;
         assign quo_src = '0;
         assign sat_src = sat8_ff;
      end else begin : g_next
         assign rem_src = dv_rem_ff[j-1];
         assign den_src = dv_den_ff[j-1];
         assign quo_src = dv_quo_ff[j-1];
         assign sat_src = dv_sat_ff[j-1];
      end

      // trial subtract of the divisor at this bit weight
      always_comb begin
         diff   = {1'b0, rem_src} - ((REM_W+1)'(den_src) << (DIV_STAGES - j));
         rem_in = diff[REM_W] ? rem_src : diff[REM_W-1:0];
         quo_in = {quo_src[PIX_W-2:0], ~diff[REM_W]};
      end

      always_ff @(posedge clock) begin
         if (stage_load[FRONT_STAGES + j]) begin
            dv_rem_ff[j] <= rem_in;
            dv_den_ff[j] <= den_src;
            dv_quo_ff[j] <= quo_in;
            dv_sat_ff[j] <= sat_src;
         end
      end
   end

   // curve at or above one gives full scale
   assign chan_out = dv_sat_ff[DIV_STAGES-1] ? PIX_MAX : dv_quo_ff[DIV_STAGES-1];

endmodule

>>> rtl/exposure_filmic_tone_map.sv
// Exposure and filmic tone map: takes one 8-bit RGB pixel per item and returns it scaled by
// 2^(EV) and passed through the ACES filmic curve, rounded to 8 bits per channel. It accepts
// one pixel every clock cycle unless the pipeline is full and the output is stalled; each
// item passes through 17 register stages, the first loaded at the accepting edge, and its
// result is presented from the last. The stages are the 9-stage front (gain multiply,
// divide by 255, curve products) plus an 8-stage restoring divider that yields one result
// bit per stage. Stalls on the output fill empty stages first, so input keeps flowing until
// the pipeline is full. The exposure register (csr_data, signed sixteenths of a stop,
// saturated to -4..+6 EV) is always ready and applies to every pixel accepted after the
// write; write it while the pipeline is empty.
`include "exposure_filmic_tone_map_assert.svh"

module exposure_filmic_tone_map
   import eftm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  eftm_pix_in_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output eftm_pix_out_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic signed [EV_W-1:0] csr_data
);

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] vld_prev;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [PIX_W-1:0]      red_res, green_res, blue_res;
   logic                  req_fire, rsp_fire;

   // a stage may load when it or some stage after it is empty, or the output moves
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_ready[i] = rsp_ready ||
            !(&(vld_ff | ((NUM_STAGES'(1) << i) - NUM_STAGES'(1))));
      end
   end

   // valid bits travel with the data
   assign vld_prev = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign vld_in   = (stage_ready & vld_prev) | (~stage_ready & vld_ff);

   // exposure gain, built when the register is written
   assign csr_ready = 1'b1;
   assign gain_in   = (csr_valid && csr_ready) ? gain_from_ev(csr_data) : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         gain_ff <= GAIN_RESET;
      end else begin
         vld_ff  <= vld_in;
         gain_ff <= gain_in;
      end
   end

   // handshakes
   assign req_ready = stage_ready[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // one datapath per channel, shared control
   eftm_chan u_red (
      .clock      (clock),
      .stage_load (stage_ready),
      .gain       (gain_ff),
      .chan_in    (req_data.red_in),
      .chan_out   (red_res)
   );

   eftm_chan u_green (
      .clock      (clock),
      .stage_load (stage_ready),
      .gain       (gain_ff),
      .chan_in    (req_data.green_in),
      .chan_out   (green_res)
   );

   eftm_chan u_blue (
      .clock      (clock),
      .stage_load (stage_ready),
      .gain       (gain_ff),
      .chan_in    (req_data.blue_in),
      .chan_out   (blue_res)
   );

   always_comb begin
      rsp_data.red_out   = red_res;
      rsp_data.green_out = green_res;
      rsp_data.blue_out  = blue_res;
   end

   // checks
   `EFTM_ASSERT_SAME(a_item_count, !$past(reset), $countones(vld_ff) == $past($countones(vld_ff)) + int'($past(req_fire)) - int'($past(rsp_fire)), "item count in the pipeline does not match the handshakes")
   `EFTM_ASSERT_SAME(a_full_stall, (&vld_ff) && !rsp_ready, !req_ready, "full stalled pipeline took an item")
   `EFTM_ASSERT_SAME(a_gain_range, 1'b1, (gain_ff >= GAIN_MIN) && (gain_ff <= GAIN_MAX), "exposure gain out of range")
   `EFTM_ASSERT_NEXT(a_csr_gain, csr_valid && csr_ready, gain_ff == gain_from_ev($past(csr_data)), "exposure gain not loaded on write")

endmodule
